>>> hdl/tksd_pkg.sv
`default_nettype none
package tksd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned TextW  = 32;
    localparam int unsigned CountW = 3;
    localparam int unsigned LaneN  = TextW / ByteW;

    typedef logic [ByteW-1:0] t_byte;

    // result kinds
    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_SPECIAL  = 2'd1;
    localparam logic [1:0] KIND_TEXT     = 2'd2;
    localparam logic [1:0] KIND_TEXT_ERR = 2'd3;

    // special keys
    localparam logic [3:0] KEY_NONE      = 4'd0;
    localparam logic [3:0] KEY_UP        = 4'd1;
    localparam logic [3:0] KEY_DOWN      = 4'd2;
    localparam logic [3:0] KEY_RIGHT     = 4'd3;
    localparam logic [3:0] KEY_LEFT      = 4'd4;
    localparam logic [3:0] KEY_HOME      = 4'd5;
    localparam logic [3:0] KEY_END       = 4'd6;
    localparam logic [3:0] KEY_DELETE    = 4'd7;
    localparam logic [3:0] KEY_PGUP      = 4'd8;
    localparam logic [3:0] KEY_PGDN      = 4'd9;
    localparam logic [3:0] KEY_TAB       = 4'd10;
    localparam logic [3:0] KEY_RETURN    = 4'd11;
    localparam logic [3:0] KEY_ESCAPE    = 4'd12;
    localparam logic [3:0] KEY_BACKSPACE = 4'd13;

    // byte values
    localparam t_byte B_TAB    = 8'd9;
    localparam t_byte B_CR     = 8'd13;
    localparam t_byte B_ESC    = 8'd27;
    localparam t_byte B_DEL    = 8'd127;
    localparam t_byte B_CTRL_Z = 8'd26;
    localparam t_byte B_LBRACK = 8'h5B;
    localparam t_byte B_UPPER_O = 8'h4F;
    localparam t_byte B_TILDE  = 8'h7E;
    localparam t_byte B_SEMI   = 8'h3B;
    localparam t_byte B_ZERO   = 8'h30;
    localparam t_byte B_ONE    = 8'h31;
    localparam t_byte B_TWO    = 8'h32;
    localparam t_byte B_THREE  = 8'h33;
    localparam t_byte B_FOUR   = 8'h34;
    localparam t_byte B_FIVE   = 8'h35;
    localparam t_byte B_SIX    = 8'h36;
    localparam t_byte B_SEVEN  = 8'h37;
    localparam t_byte B_EIGHT  = 8'h38;
    localparam t_byte B_NINE   = 8'h39;
    localparam t_byte B_CTRL_BASE = 8'h60;   // 'a' - 1

    // input modes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_IDLE = 1'b1;

    typedef struct packed {
        logic [1:0]        key_kind;
        logic [3:0]        special_key;
        t_byte             char_code;
        logic              ctrl_held;
        logic              alt_held;
        logic              shift_held;
        logic [TextW-1:0]  text_bytes;
        logic [CountW-1:0] text_count;
    } t_result;

    function automatic logic [3:0] movement_key(input t_byte b);
        logic [3:0] k;
        case (b)
            8'h41:   k = KEY_UP;
            8'h42:   k = KEY_DOWN;
            8'h43:   k = KEY_RIGHT;
            8'h44:   k = KEY_LEFT;
            8'h48:   k = KEY_HOME;
            8'h46:   k = KEY_END;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

>>> hdl/terminal_key_sequence_decoder_core.sv
`default_nettype none
// Decodes terminal input bytes and idle (read timeout) marks into key events:
// characters, Ctrl/Alt combinations, escape-sequence movement and editing keys,
// and UTF-8 text. One transfer is taken every cycle while the result register
// is free or being read; each transfer goes through an input register, one pass
// of the sequence decoder and a result register, which drives the master side.
// Transfers that only extend a pending sequence produce no result.
// s_axis_tready follows m_axis_tready combinationally: while a result waits on
// the master side, one more transfer is held in the input register and then
// the input stalls until the result is taken.
module terminal_key_sequence_decoder_core
    import tksd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    input  wire logic [0:0]  s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // special_key[3:0], char_code[11:4], ctrl_held[12], alt_held[13],
    // shift_held[14], text_bytes[46:15], text_count[49:47], zero pad[55:50]
    output logic [55:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser    // key_kind
);

    logic     r_in_valid;
    logic     r_in_mode;
    t_byte    r_in_byte;
    logic     r_out_valid;
    t_result  r_out;

    logic     step;
    logic     res_valid;
    t_result  res;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    tksd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_mode      (r_in_mode),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (step) begin
                r_out_valid <= res_valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode <= s_axis_tuser[0];
            r_in_byte <= s_axis_tdata;
        end
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.key_kind;
    assign m_axis_tdata  = {6'd0, r_out.text_count, r_out.text_bytes, r_out.shift_held,
                            r_out.alt_held, r_out.ctrl_held, r_out.char_code,
                            r_out.special_key};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !step)
        else $error("result register overwritten while held");

    a_text_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_TEXT || m_axis_tuser == KIND_TEXT_ERR))
            |-> (r_out.text_count != '0 && r_out.key_kind[1]))
        else $error("text result without bytes");

    a_special_has_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_SPECIAL)
            |-> (r_out.special_key != KEY_NONE && r_out.text_count == '0))
        else $error("special key result without a key");

    a_input_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> (!r_in_valid || $past(s_axis_tvalid)))
        else $error("input register stuck with free result slot");

endmodule
`default_nettype wire

>>> hdl/tksd_decode.sv
`default_nettype none
module tksd_decode
    import tksd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire logic    i_mode,
    input  wire t_byte   i_byte,
    output logic         o_res_valid,
    output t_result      o_res
);

    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_ESC       = 9'b000000010,
        PH_CSI       = 9'b000000100,
        PH_CSI_DIGIT = 9'b000001000,
        PH_CSI_MOD1  = 9'b000010000,
        PH_CSI_MOD2  = 9'b000100000,
        PH_SS3       = 9'b001000000,
        PH_DISCARD   = 9'b010000000,
        PH_UTF8      = 9'b100000000
    } t_phase;

    t_phase              r_phase, n_phase;
    t_byte               r_digit, n_digit;
    t_byte               r_modifier, n_modifier;
    logic [TextW-1:0]    r_text, n_text;
    logic [CountW-1:0]   r_expected, n_expected;
    logic [CountW-1:0]   r_have, n_have;

    t_result             res;
    logic                res_valid;
    logic [3:0]          move_k;
    logic [3:0]          tilde_k;
    logic [TextW-1:0]    text_ins;
    logic [CountW-1:0]   have_inc;
    logic [CountW-1:0]   lead_len;

    assign move_k   = movement_key(i_byte);
    assign have_inc = r_have + CountW'(1);

    always_comb begin
        case (r_digit)
            B_ONE, B_SEVEN: tilde_k = KEY_HOME;
            B_THREE:        tilde_k = KEY_DELETE;
            B_FOUR, B_EIGHT: tilde_k = KEY_END;
            B_FIVE:         tilde_k = KEY_PGUP;
            B_SIX:          tilde_k = KEY_PGDN;
            default:        tilde_k = KEY_NONE;
        endcase
    end

    // place the new byte in the lane given by the current count
    always_comb begin
        text_ins = r_text;
        for (int i = 0; i < LaneN; i++) begin
            if (r_have[1:0] == i[1:0]) begin
                text_ins[i*ByteW +: ByteW] = i_byte;
            end
        end
    end

    always_comb begin
        if (i_byte[7:5] == 3'b110) begin
            lead_len = CountW'(2);
        end else if (i_byte[7:4] == 4'b1110) begin
            lead_len = CountW'(3);
        end else if (i_byte[7:3] == 5'b11110) begin
            lead_len = CountW'(4);
        end else begin
            lead_len = '0;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_digit    = r_digit;
        n_modifier = r_modifier;
        n_text     = r_text;
        n_expected = r_expected;
        n_have     = r_have;
        res        = '0;
        res_valid  = 1'b0;
        if (i_step) begin
            if (i_mode == MODE_IDLE) begin
                n_phase = PH_IDLE;
                case (r_phase)
                    PH_IDLE: begin
                        res_valid = 1'b0;
                    end
                    PH_SS3: begin
                        res_valid     = 1'b1;
                        res.key_kind  = KIND_CHAR;
                        res.char_code = B_UPPER_O;
                        res.alt_held  = 1'b1;
                    end
                    PH_UTF8: begin
                        res_valid      = 1'b1;
                        res.key_kind   = KIND_TEXT_ERR;
                        res.text_bytes = r_text;
                        res.text_count = r_have;
                    end
                    default: begin
                        res_valid       = 1'b1;
                        res.key_kind    = KIND_SPECIAL;
                        res.special_key = KEY_ESCAPE;
                    end
                endcase
            end else begin
                case (r_phase)
                    PH_ESC: begin
                        n_phase = PH_IDLE;
                        if (i_byte == B_LBRACK) begin
                            n_phase = PH_CSI;
                        end else if (i_byte == B_UPPER_O) begin
                            n_phase = PH_SS3;
                        end else if (i_byte == B_CR) begin
                            res_valid       = 1'b1;
                            res.key_kind    = KIND_SPECIAL;
                            res.special_key = KEY_RETURN;
                            res.alt_held    = 1'b1;
                        end else if (i_byte != '0 && i_byte <= B_CTRL_Z) begin
                            res_valid     = 1'b1;
                            res.key_kind  = KIND_CHAR;
                            res.char_code = i_byte + B_CTRL_BASE;
                            res.ctrl_held = 1'b1;
                            res.alt_held  = 1'b1;
                        end else if (i_byte == B_DEL) begin
                            res_valid       = 1'b1;
                            res.key_kind    = KIND_SPECIAL;
                            res.special_key = KEY_BACKSPACE;
                            res.alt_held    = 1'b1;
                        end else begin
                            res_valid     = 1'b1;
                            res.key_kind  = KIND_CHAR;
                            res.char_code = i_byte;
                            res.alt_held  = 1'b1;
                        end
                    end
                    PH_CSI: begin
                        if (i_byte >= B_ZERO && i_byte <= B_NINE) begin
                            n_digit = i_byte;
                            n_phase = PH_CSI_DIGIT;
                        end else if (move_k != KEY_NONE) begin
                            n_phase         = PH_IDLE;
                            res_valid       = 1'b1;
                            res.key_kind    = KIND_SPECIAL;
                            res.special_key = move_k;
                        end else begin
                            n_phase = PH_DISCARD;
                        end
                    end
                    PH_CSI_DIGIT: begin
                        n_phase = PH_DISCARD;
                        if (i_byte == B_TILDE) begin
                            if (tilde_k != KEY_NONE) begin
                                n_phase         = PH_IDLE;
                                res_valid       = 1'b1;
                                res.key_kind    = KIND_SPECIAL;
                                res.special_key = tilde_k;
                            end
                        end else if (r_digit == B_ONE && i_byte == B_SEMI) begin
                            n_phase = PH_CSI_MOD1;
                        end
                    end
                    PH_CSI_MOD1: begin
                        n_modifier = i_byte;
                        n_phase    = PH_CSI_MOD2;
                    end
                    PH_CSI_MOD2: begin
                        if (r_modifier >= B_TWO && r_modifier <= B_SIX
                                && move_k != KEY_NONE) begin
                            n_phase         = PH_IDLE;
                            res_valid       = 1'b1;
                            res.key_kind    = KIND_SPECIAL;
                            res.special_key = move_k;
                            res.ctrl_held   = (r_modifier == B_FIVE) || (r_modifier == B_SIX);
                            res.alt_held    = (r_modifier == B_THREE) || (r_modifier == B_FOUR);
                            res.shift_held  = (r_modifier == B_TWO) || (r_modifier == B_FOUR)
                                              || (r_modifier == B_SIX);
                        end else begin
                            n_phase = PH_DISCARD;
                        end
                    end
                    PH_SS3: begin
                        if (i_byte == 8'h48 || i_byte == 8'h46) begin
                            n_phase         = PH_IDLE;
                            res_valid       = 1'b1;
                            res.key_kind    = KIND_SPECIAL;
                            res.special_key = move_k;
                        end else begin
                            n_phase = PH_DISCARD;
                        end
                    end
                    PH_DISCARD: begin
                        n_phase = PH_DISCARD;
                    end
                    PH_UTF8: begin
                        // count stays below four while collecting
                        n_text = text_ins;
                        n_have = have_inc;
                        if (have_inc >= r_expected) begin
                            n_phase        = PH_IDLE;
                            res_valid      = 1'b1;
                            res.key_kind   = KIND_TEXT;
                            res.text_bytes = text_ins;
                            res.text_count = have_inc;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (i_byte[7]) begin
                            if (lead_len == '0) begin
                                res_valid      = 1'b1;
                                res.key_kind   = KIND_TEXT_ERR;
                                res.text_bytes = TextW'(i_byte);
                                res.text_count = CountW'(1);
                            end else begin
                                n_text     = TextW'(i_byte);
                                n_expected = lead_len;
                                n_have     = CountW'(1);
                                n_phase    = PH_UTF8;
                            end
                        end else if (i_byte == B_TAB) begin
                            res_valid       = 1'b1;
                            res.key_kind    = KIND_SPECIAL;
                            res.special_key = KEY_TAB;
                        end else if (i_byte == B_CR) begin
                            res_valid       = 1'b1;
                            res.key_kind    = KIND_SPECIAL;
                            res.special_key = KEY_RETURN;
                        end else if (i_byte == B_ESC) begin
                            n_phase = PH_ESC;
                        end else if (i_byte == B_DEL) begin
                            res_valid       = 1'b1;
                            res.key_kind    = KIND_SPECIAL;
                            res.special_key = KEY_BACKSPACE;
                        end else if (i_byte != '0 && i_byte <= B_CTRL_Z) begin
                            res_valid     = 1'b1;
                            res.key_kind  = KIND_CHAR;
                            res.char_code = i_byte + B_CTRL_BASE;
                            res.ctrl_held = 1'b1;
                        end else begin
                            res_valid     = 1'b1;
                            res.key_kind  = KIND_CHAR;
                            res.char_code = i_byte;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_digit    <= '0;
            r_modifier <= '0;
            r_text     <= '0;
            r_expected <= '0;
            r_have     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_digit    <= n_digit;
            r_modifier <= n_modifier;
            r_text     <= n_text;
            r_expected <= n_expected;
            r_have     <= n_have;
        end
    end

    assign o_res_valid = res_valid;
    assign o_res       = res;

    a_utf8_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_UTF8 |-> (r_have != '0 && r_have < r_expected))
        else $error("utf8 byte count out of range");

    a_result_only_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |-> !res_valid && n_phase == r_phase)
        else $error("decoder moved without a step");

    a_idle_clears_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_mode == MODE_IDLE) |=> r_phase == PH_IDLE)
        else $error("idle mark left a sequence pending");

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import tksd_pkg::*;

    localparam int unsigned ClkHalf      = 10;
    localparam int unsigned ResetCycles  = 12;
    localparam int unsigned StallLimit   = 3000;
    localparam int unsigned DrainCycles  = 10;
    localparam int unsigned PhaseItems   = 156;
    localparam int unsigned MaxReports   = 10;

    // final bytes of escape sequences
    localparam t_byte CH_A = 8'h41;
    localparam t_byte CH_B = 8'h42;
    localparam t_byte CH_C = 8'h43;
    localparam t_byte CH_D = 8'h44;
    localparam t_byte CH_F = 8'h46;
    localparam t_byte CH_H = 8'h48;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_ESC, SEQ_CSI, SEQ_CSI_DIGIT, SEQ_CSI_MOD1,
        SEQ_CSI_MOD2, SEQ_SS3, SEQ_DISCARD, SEQ_UTF8
    } t_seq;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_EXPECT, ROW_SILENT} t_row_kind;

    typedef struct {
        t_row_kind kind;
        logic      mode;
        t_byte     data;
        t_result   want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // in_byte
    logic [0:0]  s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // special_key, char_code, ctrl_held, alt_held, shift_held, text_bytes, text_count
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;   // key_kind

    // decoder state as seen by the predictor
    t_seq              seq_state;
    t_byte             csi_digit;
    t_byte             csi_modifier;
    logic [TextW-1:0]  utf8_buf;
    logic [CountW-1:0] utf8_len;
    logic [CountW-1:0] utf8_got;

    t_result     key_events_due[$];
    t_row        directed_rows[$];
    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned items_sent;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;

    terminal_key_sequence_decoder_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(ClkHalf) i_clk = ~i_clk;

    function automatic t_result key_event(input logic [1:0] kind, input logic [3:0] key,
                                          input t_byte code, input logic c, input logic a,
                                          input logic s, input logic [TextW-1:0] text,
                                          input logic [CountW-1:0] cnt);
        t_result r;
        r.key_kind    = kind;
        r.special_key = key;
        r.char_code   = code;
        r.ctrl_held   = c;
        r.alt_held    = a;
        r.shift_held  = s;
        r.text_bytes  = text;
        r.text_count  = cnt;
        return r;
    endfunction

    function automatic logic [3:0] arrow_key(input t_byte b);
        logic [3:0] k;
        case (b)
            CH_A:    k = KEY_UP;
            CH_B:    k = KEY_DOWN;
            CH_C:    k = KEY_RIGHT;
            CH_D:    k = KEY_LEFT;
            CH_H:    k = KEY_HOME;
            CH_F:    k = KEY_END;
            default: k = KEY_NONE;
        endcase
        return k;
    endfunction

    function automatic t_result special_event(input logic [3:0] key);
        return key_event(KIND_SPECIAL, key, 8'd0, 1'b0, 1'b0, 1'b0, '0, '0);
    endfunction

    function automatic t_result char_event(input t_byte code, input logic c, input logic a);
        return key_event(KIND_CHAR, KEY_NONE, code, c, a, 1'b0, '0, '0);
    endfunction

    // advances the predicted state by one transfer, returns 1 when a key event results
    function automatic bit decode_key(input logic mode, input t_byte b, output t_result r);
        t_seq       prev;
        logic [3:0] k;
        logic [2:0] len;
        logic       c, a, s;
        prev = seq_state;
        r = '0;
        if (mode == MODE_IDLE) begin
            seq_state = SEQ_IDLE;
            case (prev)
                SEQ_IDLE: return 1'b0;
                SEQ_SS3:  r = char_event(B_UPPER_O, 1'b0, 1'b1);
                SEQ_UTF8: r = key_event(KIND_TEXT_ERR, KEY_NONE, 8'd0, 1'b0, 1'b0, 1'b0,
                                        utf8_buf, utf8_got);
                default:  r = special_event(KEY_ESCAPE);
            endcase
            return 1'b1;
        end
        case (prev)
            SEQ_ESC: begin
                seq_state = SEQ_IDLE;
                if (b == B_LBRACK) begin
                    seq_state = SEQ_CSI;
                    return 1'b0;
                end
                if (b == B_UPPER_O) begin
                    seq_state = SEQ_SS3;
                    return 1'b0;
                end
                if (b == B_CR)
                    r = key_event(KIND_SPECIAL, KEY_RETURN, 8'd0, 1'b0, 1'b1, 1'b0, '0, '0);
                else if (b >= 8'd1 && b <= B_CTRL_Z)
                    r = char_event(b + B_CTRL_BASE, 1'b1, 1'b1);
                else if (b == B_DEL)
                    r = key_event(KIND_SPECIAL, KEY_BACKSPACE, 8'd0, 1'b0, 1'b1, 1'b0, '0, '0);
                else
                    r = char_event(b, 1'b0, 1'b1);
                return 1'b1;
            end
            SEQ_CSI: begin
                if (b >= B_ZERO && b <= B_NINE) begin
                    csi_digit = b;
                    seq_state = SEQ_CSI_DIGIT;
                    return 1'b0;
                end
                k = arrow_key(b);
                if (k != KEY_NONE) begin
                    seq_state = SEQ_IDLE;
                    r = special_event(k);
                    return 1'b1;
                end
                seq_state = SEQ_DISCARD;
                return 1'b0;
            end
            SEQ_CSI_DIGIT: begin
                if (b == B_TILDE) begin
                    case (csi_digit)
                        B_ONE, B_SEVEN: k = KEY_HOME;
                        B_THREE:        k = KEY_DELETE;
                        B_FOUR, B_EIGHT: k = KEY_END;
                        B_FIVE:         k = KEY_PGUP;
                        B_SIX:          k = KEY_PGDN;
                        default:        k = KEY_NONE;
                    endcase
                    if (k != KEY_NONE) begin
                        seq_state = SEQ_IDLE;
                        r = special_event(k);
                        return 1'b1;
                    end
                end else if (csi_digit == B_ONE && b == B_SEMI) begin
                    seq_state = SEQ_CSI_MOD1;
                    return 1'b0;
                end
                seq_state = SEQ_DISCARD;
                return 1'b0;
            end
            SEQ_CSI_MOD1: begin
                csi_modifier = b;
                seq_state = SEQ_CSI_MOD2;
                return 1'b0;
            end
            SEQ_CSI_MOD2: begin
                k = arrow_key(b);
                if (csi_modifier >= B_TWO && csi_modifier <= B_SIX && k != KEY_NONE) begin
                    c = (csi_modifier == B_FIVE || csi_modifier == B_SIX);
                    a = (csi_modifier == B_THREE || csi_modifier == B_FOUR);
                    s = (csi_modifier == B_TWO || csi_modifier == B_FOUR
                         || csi_modifier == B_SIX);
                    seq_state = SEQ_IDLE;
                    r = key_event(KIND_SPECIAL, k, 8'd0, c, a, s, '0, '0);
                    return 1'b1;
                end
                seq_state = SEQ_DISCARD;
                return 1'b0;
            end
            SEQ_SS3: begin
                if (b == CH_H || b == CH_F) begin
                    seq_state = SEQ_IDLE;
                    r = special_event(b == CH_H ? KEY_HOME : KEY_END);
                    return 1'b1;
                end
                seq_state = SEQ_DISCARD;
                return 1'b0;
            end
            SEQ_DISCARD: return 1'b0;
            SEQ_UTF8: begin
                // continuation bytes are taken as they come, unchecked
                if (utf8_got < 3'd4)
                    utf8_buf = utf8_buf | ({24'd0, b} << (8 * utf8_got));
                utf8_got = utf8_got + 3'd1;
                if (utf8_got >= utf8_len || utf8_got >= 3'd4) begin
                    seq_state = SEQ_IDLE;
                    r = key_event(KIND_TEXT, KEY_NONE, 8'd0, 1'b0, 1'b0, 1'b0,
                                  utf8_buf, utf8_got);
                    return 1'b1;
                end
                return 1'b0;
            end
            default: ;
        endcase
        // first byte of a key
        seq_state = SEQ_IDLE;
        if (b >= 8'h80) begin
            if (b >= 8'hC0 && b <= 8'hDF)      len = 3'd2;
            else if (b >= 8'hE0 && b <= 8'hEF) len = 3'd3;
            else if (b >= 8'hF0 && b <= 8'hF7) len = 3'd4;
            else                               len = 3'd0;
            if (len == 3'd0) begin
                r = key_event(KIND_TEXT_ERR, KEY_NONE, 8'd0, 1'b0, 1'b0, 1'b0,
                              {24'd0, b}, 3'd1);
                return 1'b1;
            end
            utf8_buf  = {24'd0, b};
            utf8_len  = len;
            utf8_got  = 3'd1;
            seq_state = SEQ_UTF8;
            return 1'b0;
        end
        if (b == B_TAB)      r = special_event(KEY_TAB);
        else if (b == B_CR)  r = special_event(KEY_RETURN);
        else if (b == B_ESC) begin
            seq_state = SEQ_ESC;
            return 1'b0;
        end
        else if (b == B_DEL) r = special_event(KEY_BACKSPACE);
        else if (b >= 8'd1 && b <= B_CTRL_Z) r = char_event(b + B_CTRL_BASE, 1'b1, 1'b0);
        else r = char_event(b, 1'b0, 1'b0);
        return 1'b1;
    endfunction

    task automatic send_item(input logic mode, input t_byte b, input t_row_kind kind,
                             input t_result want);
        t_result r;
        bit      has;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        has = decode_key(mode, b, r);
        items_sent++;
        case (kind)
            ROW_PREDICT: if (has) key_events_due = {key_events_due, r};
            ROW_EXPECT:  key_events_due = {key_events_due, want};
            default: ;
        endcase
    endtask

    task automatic send_byte(input t_byte b);
        send_item(MODE_BYTE, b, ROW_PREDICT, '0);
    endtask

    task automatic send_idle();
        send_item(MODE_IDLE, t_byte'($urandom_range(0, 255)), ROW_PREDICT, '0);
    endtask

    function automatic t_byte pick_final();
        case ($urandom_range(0, 6))
            0:       return CH_A;
            1:       return CH_B;
            2:       return CH_C;
            3:       return CH_D;
            4:       return CH_H;
            5:       return CH_F;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_byte pick_digit();
        return t_byte'($urandom_range(B_ZERO, B_NINE));
    endfunction

    // one well-formed sequence with random content, or a bit of noise
    task automatic send_random_key();
        int unsigned n;
        t_byte       lead;
        case ($urandom_range(0, 15))
            0: send_byte(t_byte'($urandom_range(0, 255)));
            1: send_byte(t_byte'($urandom_range(8'h20, 8'h7E)));
            2: send_byte(t_byte'($urandom_range(0, 31)));
            3: send_idle();
            4: begin
                send_byte(B_ESC);
                send_byte(t_byte'($urandom_range(0, 255)));
            end
            5, 6: begin
                send_byte(B_ESC);
                send_byte(B_LBRACK);
                send_byte(pick_final());
            end
            7: begin
                send_byte(B_ESC);
                send_byte(B_LBRACK);
                send_byte(pick_digit());
                send_byte($urandom_range(0, 4) != 0 ? B_TILDE
                                                    : t_byte'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) send_idle();
            end
            8: begin
                send_byte(B_ESC);
                send_byte(B_LBRACK);
                send_byte($urandom_range(0, 5) != 0 ? B_ONE : pick_digit());
                send_byte($urandom_range(0, 5) != 0 ? B_SEMI : t_byte'($urandom_range(0, 255)));
                send_byte($urandom_range(0, 4) != 0 ? t_byte'($urandom_range(B_TWO, B_SIX))
                                                    : pick_digit());
                send_byte(pick_final());
                if ($urandom_range(0, 2) == 0) send_idle();
            end
            9: begin
                send_byte(B_ESC);
                send_byte(B_UPPER_O);
                case ($urandom_range(0, 3))
                    0:       send_idle();
                    1:       send_byte(CH_H);
                    2:       send_byte(CH_F);
                    default: begin
                        send_byte(t_byte'($urandom_range(0, 255)));
                        send_idle();
                    end
                endcase
            end
            10: begin
                send_byte(B_ESC);
                send_idle();
            end
            11: begin
                // unknown sequence, swallowed until idle
                send_byte(B_ESC);
                send_byte(B_LBRACK);
                n = $urandom_range(1, 4);
                repeat (n) send_byte(t_byte'($urandom_range(0, 255)));
                send_idle();
            end
            12, 13: begin
                case ($urandom_range(0, 2))
                    0:       lead = t_byte'($urandom_range(8'hC0, 8'hDF));
                    1:       lead = t_byte'($urandom_range(8'hE0, 8'hEF));
                    default: lead = t_byte'($urandom_range(8'hF0, 8'hF7));
                endcase
                send_byte(lead);
                n = lead >= 8'hF0 ? 3 : (lead >= 8'hE0 ? 2 : 1);
                if ($urandom_range(0, 4) == 0) begin
                    n = $urandom_range(0, n - 1);
                    repeat (n) send_byte(t_byte'($urandom_range(0, 255)));
                    send_idle();
                end else begin
                    repeat (n) send_byte(t_byte'($urandom_range(8'h80, 8'hBF)));
                end
            end
            14: send_byte($urandom_range(0, 1) ? t_byte'($urandom_range(8'h80, 8'hBF))
                                               : t_byte'($urandom_range(8'hF8, 8'hFF)));
            default: send_item(logic'($urandom_range(0, 1)), t_byte'($urandom_range(0, 255)),
                               ROW_PREDICT, '0);
        endcase
    endtask

    task automatic add_row(input t_row_kind kind, input logic mode, input t_byte b,
                           input t_result want);
        t_row row;
        row.kind = kind;
        row.mode = mode;
        row.data = b;
        row.want = want;
        directed_rows = {directed_rows, row};
    endtask

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.key_kind    = m_axis_tuser;
            got.special_key = m_axis_tdata[3:0];
            got.char_code   = m_axis_tdata[11:4];
            got.ctrl_held   = m_axis_tdata[12];
            got.alt_held    = m_axis_tdata[13];
            got.shift_held  = m_axis_tdata[14];
            got.text_bytes  = m_axis_tdata[46:15];
            got.text_count  = m_axis_tdata[49:47];
            if (key_events_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("unexpected key event: kind=%0d key=%0d char=%02h text=%08h",
                             got.key_kind, got.special_key, got.char_code, got.text_bytes);
            end else begin
                want = key_events_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MaxReports) begin
                        $display("key event mismatch at %0t", $realtime);
                        $write("  expected kind=%0d key=%0d char=%02h ctrl=%0d alt=%0d",
                               want.key_kind, want.special_key, want.char_code,
                               want.ctrl_held, want.alt_held);
                        $display(" shift=%0d text=%08h count=%0d",
                                 want.shift_held, want.text_bytes, want.text_count);
                        $write("  actual   kind=%0d key=%0d char=%02h ctrl=%0d alt=%0d",
                               got.key_kind, got.special_key, got.char_code,
                               got.ctrl_held, got.alt_held);
                        $display(" shift=%0d text=%08h count=%0d",
                                 got.shift_held, got.text_bytes, got.text_count);
                    end
                end
            end
        end
    end

    // ends the run if no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int unsigned phase_end;
        mismatches     = 0;
        quiet_cycles   = 0;
        items_sent     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        seq_state      = SEQ_IDLE;
        csi_digit      = '0;
        csi_modifier   = '0;
        utf8_buf       = '0;
        utf8_len       = '0;
        utf8_got       = '0;
        i_rst_n        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= MODE_BYTE;
        m_axis_tready  <= 1'b0;

        // directed sequences: extremes, control bytes, modifiers, timeouts, utf8
        add_row(ROW_SILENT,  MODE_IDLE, 8'h00, '0);
        add_row(ROW_EXPECT,  MODE_BYTE, 8'h00, char_event(8'h00, 1'b0, 1'b0));
        add_row(ROW_EXPECT,  MODE_BYTE, B_TILDE, char_event(B_TILDE, 1'b0, 1'b0));
        add_row(ROW_EXPECT,  MODE_BYTE, B_TAB, special_event(KEY_TAB));
        add_row(ROW_EXPECT,  MODE_BYTE, B_CR, special_event(KEY_RETURN));
        add_row(ROW_EXPECT,  MODE_BYTE, B_DEL, special_event(KEY_BACKSPACE));
        add_row(ROW_EXPECT,  MODE_BYTE, 8'd1, char_event(8'h61, 1'b1, 1'b0));
        add_row(ROW_EXPECT,  MODE_BYTE, 8'hFF,
                key_event(KIND_TEXT_ERR, KEY_NONE, 8'd0, 1'b0, 1'b0, 1'b0, 32'hFF, 3'd1));
        add_row(ROW_SILENT,  MODE_BYTE, B_ESC, '0);
        add_row(ROW_SILENT,  MODE_BYTE, B_LBRACK, '0);
        add_row(ROW_SILENT,  MODE_BYTE, B_ONE, '0);
        add_row(ROW_SILENT,  MODE_BYTE, B_SEMI, '0);
        add_row(ROW_SILENT,  MODE_BYTE, B_SIX, '0);
        add_row(ROW_PREDICT, MODE_BYTE, CH_D, '0);
        add_row(ROW_SILENT,  MODE_BYTE, B_ESC, '0);
        add_row(ROW_SILENT,  MODE_BYTE, B_UPPER_O, '0);
        add_row(ROW_EXPECT,  MODE_IDLE, 8'hFF, char_event(B_UPPER_O, 1'b0, 1'b1));
        add_row(ROW_SILENT,  MODE_BYTE, B_ESC, '0);
        add_row(ROW_EXPECT,  MODE_BYTE, B_ESC, char_event(B_ESC, 1'b0, 1'b1));
        add_row(ROW_SILENT,  MODE_BYTE, 8'hF0, '0);
        add_row(ROW_SILENT,  MODE_BYTE, 8'h9F, '0);
        add_row(ROW_SILENT,  MODE_BYTE, 8'h98, '0);
        add_row(ROW_EXPECT,  MODE_BYTE, 8'h80,
                key_event(KIND_TEXT, KEY_NONE, 8'd0, 1'b0, 1'b0, 1'b0, 32'h80989FF0, 3'd4));
        add_row(ROW_SILENT,  MODE_BYTE, 8'hE2, '0);
        add_row(ROW_EXPECT,  MODE_IDLE, 8'h00,
                key_event(KIND_TEXT_ERR, KEY_NONE, 8'd0, 1'b0, 1'b0, 1'b0, 32'hE2, 3'd1));

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].kind,
                      directed_rows[i].want);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 54; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 54; end
                default: begin src_idle_pct = 9;  sink_stall_pct = 9;  end
            endcase
            phase_end = items_sent + PhaseItems;
            while (items_sent < phase_end) send_random_key();
        end
        s_axis_tvalid <= 1'b0;

        while (key_events_due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
